// ===== rtl/udp_socket_demux_table_macros.svh =====
// Assertion macros shared by the socket table modules.
`ifndef UDP_SOCKET_DEMUX_TABLE_MACROS_SVH
`define UDP_SOCKET_DEMUX_TABLE_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle.
`define UDT_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);
// Assert that a condition implies a consequence in the next cycle.
`define UDT_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/udt_pkg.sv =====
// ----------------------------------------------------------------------------
// udt_pkg
// Shared types and constants of the socket table.
// ----------------------------------------------------------------------------
package udt_pkg;
	localparam int Sockets = 16;
	localparam int RingSlots = 8;
	localparam int MaxPayload = 1472;
	localparam int SidW = 4;
	localparam int RpW = 3;
	localparam int CntW = 4;
	localparam logic [15:0] EphBase = 16'd40000;
	localparam logic [14:0] EphTries = 15'd20000;

	localparam logic [2:0] CMD_OPEN = 3'd0;
	localparam logic [2:0] CMD_BIND = 3'd1;
	localparam logic [2:0] CMD_CONNECT = 3'd2;
	localparam logic [2:0] CMD_CLOSE = 3'd3;
	localparam logic [2:0] CMD_UDP = 3'd4;
	localparam logic [2:0] CMD_ICMP = 3'd5;
	localparam logic [2:0] CMD_POP = 3'd6;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_FAMILY = 3'd2;
	localparam logic [2:0] ST_PROTO = 3'd3;
	localparam logic [2:0] ST_NOFREE = 3'd4;
	localparam logic [2:0] ST_INUSE = 3'd5;
	localparam logic [2:0] ST_EMPTY = 3'd6;
	localparam logic [2:0] ST_BADDESC = 3'd7;

	typedef struct packed {
		logic [2:0] cmd;
		logic [3:0] sid;
		logic family_inet;
		logic [1:0] sock_type;
		logic [7:0] protocol;
		logic [31:0] ip_addr;
		logic [15:0] port;
		logic [31:0] dst_ip;
		logic [15:0] dest_port;
		logic [10:0] len;
		logic [15:0] handle;
	} cmd_t;

	localparam int QDepth = 2;
endpackage

// ===== rtl/udt_front.sv =====
// ----------------------------------------------------------------------------
// udt_front
// Accepts command beats, clips the length and queues them for the engine.
// ----------------------------------------------------------------------------
`include "udp_socket_demux_table_macros.svh"
module udt_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] cmd,
	input logic [3:0] socket_id,
	input logic family_inet,
	input logic [1:0] sock_type,
	input logic [7:0] protocol,
	input logic [31:0] ip_addr,
	input logic [15:0] port,
	input logic [31:0] dst_ip,
	input logic [15:0] dest_port,
	input logic [15:0] pkt_len,
	input logic [15:0] payload_handle,
	output logic q_valid,
	output udt_pkg::cmd_t q_item,
	input logic q_pop
);
	udt_pkg::cmd_t mem_q [udt_pkg::QDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	udt_pkg::cmd_t item;
	logic push;

	assign busy = (cnt_q == 2'(udt_pkg::QDepth));
	assign push = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rp_q];

	always_comb begin
		item.cmd = cmd;
		item.sid = socket_id;
		item.family_inet = family_inet;
		item.sock_type = sock_type;
		item.protocol = protocol;
		item.ip_addr = ip_addr;
		item.port = port;
		item.dst_ip = dst_ip;
		item.dest_port = dest_port;
		item.len = (pkt_len > 16'(udt_pkg::MaxPayload)) ? 11'(udt_pkg::MaxPayload)
			: pkt_len[10:0];
		item.handle = payload_handle;
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	`UDT_ASSERT_IMP(a_no_pop_empty, clk, arst_n, q_pop, cnt_q != 2'd0, "pop of empty queue")
	`UDT_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= 2'(udt_pkg::QDepth), "queue overflow")
	`UDT_ASSERT_NEXT(a_push_counts, clk, arst_n, push && !q_pop, cnt_q == $past(cnt_q) + 2'd1, "push not counted")
endmodule

// ===== rtl/udt_engine.sv =====
// ----------------------------------------------------------------------------
// udt_engine
// Executes commands against the socket table, scanning one slot per cycle.
// ----------------------------------------------------------------------------
`include "udp_socket_demux_table_macros.svh"
module udt_engine (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input udt_pkg::cmd_t q_item,
	output logic q_pop,
	output logic done,
	output logic [2:0] status,
	output logic [3:0] socket_out,
	output logic [31:0] ip_out,
	output logic [15:0] port_out,
	output logic [10:0] length_out,
	output logic [15:0] handle_out,
	output logic [15:0] accepted_mask
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_EPH = 3'd2;
	localparam logic [2:0] S_POPRD = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	udt_pkg::cmd_t c_q;
	logic [3:0] i_q;
	logic [15:0] cand_q;
	logic [14:0] tries_q;
	logic hit_q;

	logic [15:0] open_q, raw_q, bound_q, conn_q;
	logic [15:0] lport_q [16];
	logic [31:0] laddr_q [16];
	logic [15:0] rport_q [16];
	logic [31:0] raddr_q [16];
	logic [2:0] rdp_q [16];
	logic [2:0] wrp_q [16];
	logic [3:0] cnt_q [16];
	logic [15:0] eph_q;

	logic [31:0] rsrc_mem [128];
	logic [42:0] rmeta_mem [128];
	logic [31:0] rd_src_q;
	logic [42:0] rd_meta_q;

	logic [2:0] st_q;
	logic [3:0] so_q;
	logic [15:0] po_q, mask_q;

	// Per-slot conflict check for the bind currently in progress.
	logic bind_raw;
	logic [15:0] bport;
	logic [31:0] baddr;
	logic conflict;
	logic udp_match, icmp_match;
	logic [6:0] widx;
	logic free_found;
	logic [3:0] free_idx;
	logic sid_valid;

	assign sid_valid = open_q[c_q.sid];
	assign bind_raw = raw_q[c_q.sid];
	assign bport = (state_q == S_EPH) ? cand_q : c_q.port;
	// An ephemeral candidate is always checked against the wildcard address.
	assign baddr = (state_q == S_SCAN && c_q.cmd == udt_pkg::CMD_BIND) ? c_q.ip_addr : 32'd0;
	assign conflict = open_q[i_q] && bound_q[i_q] && (raw_q[i_q] == bind_raw)
		&& (lport_q[i_q] == bport)
		&& (laddr_q[i_q] == 32'd0 || baddr == 32'd0 || laddr_q[i_q] == baddr);
	assign udp_match = open_q[i_q] && !raw_q[i_q] && bound_q[i_q]
		&& lport_q[i_q] == c_q.dest_port
		&& (laddr_q[i_q] == 32'd0 || laddr_q[i_q] == c_q.dst_ip)
		&& !(conn_q[i_q] && (raddr_q[i_q] != c_q.ip_addr
			|| (rport_q[i_q] != 16'd0 && rport_q[i_q] != c_q.port)));
	assign icmp_match = open_q[i_q] && raw_q[i_q]
		&& !(conn_q[i_q] && raddr_q[i_q] != c_q.ip_addr);
	assign widx = {i_q, wrp_q[i_q]};

	always_comb begin
		free_found = 1'b0;
		free_idx = 4'd0;
		for (int k = 15; k >= 0; k--) begin
			if (!open_q[k]) begin
				free_found = 1'b1;
				free_idx = 4'(k);
			end
		end
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign done = (state_q == S_DONE);
	assign status = st_q;
	assign socket_out = so_q;
	assign port_out = po_q;
	assign accepted_mask = mask_q;
	assign ip_out = (done && c_q.cmd == udt_pkg::CMD_POP && st_q == udt_pkg::ST_OK)
		? rd_src_q : 32'd0;
	assign length_out = (done && c_q.cmd == udt_pkg::CMD_POP && st_q == udt_pkg::ST_OK)
		? rd_meta_q[26:16] : 11'd0;
	assign handle_out = (done && c_q.cmd == udt_pkg::CMD_POP && st_q == udt_pkg::ST_OK)
		? rd_meta_q[15:0] : 16'd0;

	logic push_now;
	logic [42:0] meta_w;
	assign meta_w = {(c_q.cmd == udt_pkg::CMD_UDP) ? c_q.port : 16'd0, c_q.len, c_q.handle};
	assign push_now = (state_q == S_SCAN) && cnt_q[i_q] != 4'(udt_pkg::RingSlots)
		&& ((c_q.cmd == udt_pkg::CMD_UDP && udp_match)
			|| (c_q.cmd == udt_pkg::CMD_ICMP && icmp_match));

	always_ff @(posedge clk) begin
		if (push_now) begin
			rsrc_mem[widx] <= c_q.ip_addr;
			rmeta_mem[widx] <= meta_w;
		end
		rd_src_q <= rsrc_mem[{c_q.sid, rdp_q[c_q.sid]}];
		rd_meta_q <= rmeta_mem[{c_q.sid, rdp_q[c_q.sid]}];
		if (q_pop) c_q <= q_item;
	end

	logic [15:0] eph_inc;
	assign eph_inc = eph_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			open_q <= '0;
			raw_q <= '0;
			bound_q <= '0;
			conn_q <= '0;
			for (int k = 0; k < 16; k++) begin
				lport_q[k] <= '0;
				laddr_q[k] <= '0;
				rport_q[k] <= '0;
				raddr_q[k] <= '0;
				rdp_q[k] <= '0;
				wrp_q[k] <= '0;
				cnt_q[k] <= '0;
			end
			eph_q <= udt_pkg::EphBase;
			i_q <= '0;
			cand_q <= '0;
			tries_q <= '0;
			hit_q <= 1'b0;
			st_q <= '0;
			so_q <= '0;
			po_q <= '0;
			mask_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_SCAN;
						i_q <= '0;
						hit_q <= 1'b0;
						st_q <= udt_pkg::ST_OK;
						so_q <= '0;
						po_q <= '0;
						mask_q <= '0;
						tries_q <= '0;
					end
				end
				S_SCAN: begin
					state_q <= S_DONE;
					unique case (c_q.cmd)
						udt_pkg::CMD_OPEN: begin
							if (!c_q.family_inet) st_q <= udt_pkg::ST_FAMILY;
							else if (c_q.sock_type == 2'd0 && c_q.protocol != 8'd0
								&& c_q.protocol != 8'd17) st_q <= udt_pkg::ST_PROTO;
							else if (c_q.sock_type == 2'd1 && c_q.protocol != 8'd0
								&& c_q.protocol != 8'd1) st_q <= udt_pkg::ST_PROTO;
							else if (c_q.sock_type[1]) st_q <= udt_pkg::ST_PROTO;
							else if (!free_found) st_q <= udt_pkg::ST_NOFREE;
							else begin
								open_q[free_idx] <= 1'b1;
								raw_q[free_idx] <= c_q.sock_type == 2'd1;
								bound_q[free_idx] <= 1'b0;
								conn_q[free_idx] <= 1'b0;
								lport_q[free_idx] <= '0;
								laddr_q[free_idx] <= '0;
								rport_q[free_idx] <= '0;
								raddr_q[free_idx] <= '0;
								rdp_q[free_idx] <= '0;
								wrp_q[free_idx] <= '0;
								cnt_q[free_idx] <= '0;
								so_q <= free_idx;
							end
						end
						udt_pkg::CMD_BIND, udt_pkg::CMD_CONNECT: begin
							if (!sid_valid) st_q <= udt_pkg::ST_INVALID;
							else if (!c_q.family_inet) st_q <= udt_pkg::ST_FAMILY;
							else if (c_q.cmd == udt_pkg::CMD_CONNECT && bound_q[c_q.sid]) begin
								raddr_q[c_q.sid] <= c_q.ip_addr;
								rport_q[c_q.sid] <= c_q.port;
								conn_q[c_q.sid] <= 1'b1;
								po_q <= lport_q[c_q.sid];
							end else if (c_q.cmd == udt_pkg::CMD_BIND && c_q.port != 16'd0)
							begin
								// Explicit port: scan the table for a conflict.
								if (conflict) hit_q <= 1'b1;
								if (i_q != 4'd15) begin
									i_q <= i_q + 4'd1;
									state_q <= S_SCAN;
								end else if (conflict || hit_q) st_q <= udt_pkg::ST_INUSE;
								else begin
									lport_q[c_q.sid] <= c_q.port;
									laddr_q[c_q.sid] <= c_q.ip_addr;
									bound_q[c_q.sid] <= 1'b1;
									po_q <= c_q.port;
								end
							end else begin
								cand_q <= eph_q;
								eph_q <= (eph_inc < udt_pkg::EphBase) ? udt_pkg::EphBase
									: eph_inc;
								tries_q <= tries_q + 15'd1;
								i_q <= '0;
								hit_q <= 1'b0;
								state_q <= S_EPH;
							end
						end
						udt_pkg::CMD_CLOSE: begin
							if (!sid_valid) st_q <= udt_pkg::ST_BADDESC;
							else begin
								open_q[c_q.sid] <= 1'b0;
								raw_q[c_q.sid] <= 1'b0;
								bound_q[c_q.sid] <= 1'b0;
								conn_q[c_q.sid] <= 1'b0;
								lport_q[c_q.sid] <= '0;
								laddr_q[c_q.sid] <= '0;
								rport_q[c_q.sid] <= '0;
								raddr_q[c_q.sid] <= '0;
								rdp_q[c_q.sid] <= '0;
								wrp_q[c_q.sid] <= '0;
								cnt_q[c_q.sid] <= '0;
							end
						end
						udt_pkg::CMD_UDP, udt_pkg::CMD_ICMP: begin
							if (push_now) begin
								wrp_q[i_q] <= wrp_q[i_q] + 3'd1;
								cnt_q[i_q] <= cnt_q[i_q] + 4'd1;
								mask_q[i_q] <= 1'b1;
							end
							// UDP stops at the first matching socket, full or not.
							if (!(c_q.cmd == udt_pkg::CMD_UDP && udp_match) && i_q != 4'd15)
							begin
								i_q <= i_q + 4'd1;
								state_q <= S_SCAN;
							end
						end
						udt_pkg::CMD_POP: begin
							if (!sid_valid) st_q <= udt_pkg::ST_INVALID;
							else if (cnt_q[c_q.sid] == 4'd0) st_q <= udt_pkg::ST_EMPTY;
							else state_q <= S_POPRD;
						end
						default: st_q <= udt_pkg::ST_INVALID;
					endcase
				end
				S_EPH: begin
					// Candidate ephemeral port: scan the table, one slot per cycle.
					if (conflict) hit_q <= 1'b1;
					if (i_q != 4'd15) i_q <= i_q + 4'd1;
					else if (!(conflict || hit_q)) begin
						lport_q[c_q.sid] <= cand_q;
						laddr_q[c_q.sid] <= (c_q.cmd == udt_pkg::CMD_BIND) ? c_q.ip_addr
							: 32'd0;
						bound_q[c_q.sid] <= 1'b1;
						po_q <= cand_q;
						if (c_q.cmd == udt_pkg::CMD_CONNECT) begin
							raddr_q[c_q.sid] <= c_q.ip_addr;
							rport_q[c_q.sid] <= c_q.port;
							conn_q[c_q.sid] <= 1'b1;
						end
						state_q <= S_DONE;
					end else if (tries_q == udt_pkg::EphTries) begin
						st_q <= udt_pkg::ST_INUSE;
						state_q <= S_DONE;
					end else begin
						cand_q <= eph_q;
						eph_q <= (eph_inc < udt_pkg::EphBase) ? udt_pkg::EphBase : eph_inc;
						tries_q <= tries_q + 15'd1;
						i_q <= '0;
						hit_q <= 1'b0;
					end
				end
				S_POPRD: begin
					// The ring entry was read at the end of the scan cycle.
					po_q <= rd_meta_q[42:27];
					rdp_q[c_q.sid] <= rdp_q[c_q.sid] + 3'd1;
					cnt_q[c_q.sid] <= cnt_q[c_q.sid] - 4'd1;
					state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`UDT_ASSERT_IMP(a_pop_idle, clk, arst_n, q_pop, state_q == S_IDLE, "pop outside idle")
	`UDT_ASSERT_NEXT(a_done_one, clk, arst_n, done, !done, "result held two cycles")
	`UDT_ASSERT_IMP(a_mask_udp, clk, arst_n, done && c_q.cmd == udt_pkg::CMD_UDP, $countones(mask_q) <= 1, "udp queued on many sockets")
endmodule

// ===== rtl/udp_socket_demux_table.sv =====
// Open, close, bound connect and errors need no table scan; a pop adds a ring read,
// delivery and explicit bind scan the table, and each ephemeral try rescans it.
// Commands run one at a time, paced by the one-slot-per-cycle table scan; a
// two-entry queue takes new beats while a command runs, until it is full.
// Reset: arst_n clears every slot, the rings and the port allocator to 40000.
// Results appear on done for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// udp_socket_demux_table
// Socket table with per-socket receive rings.
// ----------------------------------------------------------------------------
module udp_socket_demux_table (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] cmd,
	input logic [3:0] socket_id,
	input logic family_inet,
	input logic [1:0] sock_type,
	input logic [7:0] protocol,
	input logic [31:0] ip_addr,
	input logic [15:0] port,
	input logic [31:0] dst_ip,
	input logic [15:0] dest_port,
	input logic [15:0] pkt_len,
	input logic [15:0] payload_handle,
	output logic done,
	output logic [2:0] status,
	output logic [3:0] socket_out,
	output logic [31:0] ip_out,
	output logic [15:0] port_out,
	output logic [10:0] length_out,
	output logic [15:0] handle_out,
	output logic [15:0] accepted_mask
);
	logic q_valid, q_pop;
	udt_pkg::cmd_t q_item;

	udt_front u_front (
		.clk, .arst_n, .start, .busy, .cmd, .socket_id, .family_inet, .sock_type,
		.protocol, .ip_addr, .port, .dst_ip, .dest_port, .pkt_len, .payload_handle,
		.q_valid, .q_item, .q_pop
	);

	udt_engine u_engine (
		.clk, .arst_n, .q_valid, .q_item, .q_pop, .done, .status, .socket_out,
		.ip_out, .port_out, .length_out, .handle_out, .accepted_mask
	);
endmodule
